### sv/smss_pkg.sv
package smss_pkg;

    localparam int SAMPLE_SLOTS_DEF = 128;

    localparam int POS_W = 32;
    localparam int LVL_W = 10;
    localparam int MEM_W = POS_W + LVL_W;
    localparam int CFG_W = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [1:0] REG_SEGMENT = 2'd0;
    localparam logic [1:0] REG_SETTLE = 2'd1;
    localparam logic [1:0] REG_RATE = 2'd2;

    localparam logic [CFG_W-1:0] SEGMENT_RST = 16'd100;
    localparam logic [CFG_W-1:0] SETTLE_RST = 16'd1000;
    localparam logic [CFG_W-1:0] RATE_RST = 16'd1000;

    localparam logic [2:0] PHASE_IDLE = 3'd0;
    localparam logic [2:0] PHASE_SETTLE = 3'd1;
    localparam logic [2:0] PHASE_MOVE = 3'd2;
    localparam logic [2:0] PHASE_SAMPLE = 3'd3;
    localparam logic [2:0] PHASE_DONE = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_SETTLE = 5'b00010,
        PH_MOVE   = 5'b00100,
        PH_SAMPLE = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic              move_start;
        logic [31:0]       move_count;
        logic              move_direction;
        logic              move_abort;
        logic signed [31:0] deviation;
        logic              deviation_flag;
        logic [2:0]        phase;
        logic [7:0]        samples_taken;
        logic              rd_hit;
    } t_result;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:   code = PHASE_IDLE;
            PH_SETTLE: code = PHASE_SETTLE;
            PH_MOVE:   code = PHASE_MOVE;
            PH_SAMPLE: code = PHASE_SAMPLE;
            PH_DONE:   code = PHASE_DONE;
            default:   code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage

### sv/smss_ram.sv
module smss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/smss_ctrl.sv
module smss_ctrl #(
    parameter int SAMPLE_SLOTS = smss_pkg::SAMPLE_SLOTS_DEF,
    parameter int IW = $clog2(SAMPLE_SLOTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_operation,
    input  logic                          i_direction,
    input  logic signed [31:0]            i_encoder_position,
    input  logic [9:0]                    i_analog_level,
    input  logic                          i_pulses_done,
    input  logic [6:0]                    i_read_index,
    input  logic [smss_pkg::CFG_W-1:0]    i_segment_pulses,
    input  logic [smss_pkg::CFG_W-1:0]    i_settle_ticks,
    output smss_pkg::t_result             o_res,
    output logic                          o_mem_we,
    output logic [IW-1:0]                 o_mem_waddr,
    output logic [smss_pkg::MEM_W-1:0]    o_mem_wdata,
    output logic                          o_mem_re,
    output logic [IW-1:0]                 o_mem_raddr
);

    import smss_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(SAMPLE_SLOTS - 1);

    t_phase            r_phase, n_phase;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CFG_W-1:0]  r_settle, n_settle;
    logic [31:0]       r_origin, n_origin;
    logic              r_dir, n_dir;

    logic [IW-1:0]     tgt_idx;
    logic [CFG_W+IW-1:0] prod;
    logic [31:0]       span;
    logic [31:0]       target;
    logic [31:0]       diff;
    logic [31:0]       diff_abs;
    logic              diff_big;
    logic [CFG_W-1:0]  settle_inc;
    logic              we, re;
    t_result           res;

    // ideal target of the current slot while moving, of the next slot while sampling
    always_comb begin
        tgt_idx  = (r_phase == PH_MOVE) ? r_idx : IW'(r_idx + 1'b1);
        prod     = i_segment_pulses * tgt_idx;
        span     = 32'(prod);
        target   = r_dir ? (r_origin - span) : (r_origin + span);
        diff     = target - i_encoder_position;
        diff_abs = diff[31] ? (32'd0 - diff) : diff;
        diff_big = !(diff == 32'd0 || diff == 32'd1 || diff == 32'hFFFF_FFFF);
        settle_inc = (r_settle != {CFG_W{1'b1}}) ? (r_settle + 1'b1) : r_settle;
    end

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_settle = r_settle;
        n_origin = r_origin;
        n_dir    = r_dir;
        we       = 1'b0;
        re       = 1'b0;
        o_mem_waddr = r_idx;
        res      = '0;
        case (i_operation)
            OP_START: begin
                n_idx    = '0;
                n_origin = i_encoder_position;
                n_dir    = i_direction;
                n_settle = '0;
                n_phase  = PH_SETTLE;
                we       = 1'b1;
                o_mem_waddr = '0;
            end
            OP_STOP: begin
                res.move_abort = 1'b1;
                n_phase        = PH_IDLE;
            end
            OP_READ: begin
                re         = 1'b1;
                res.rd_hit = ({25'd0, i_read_index} < 32'(SAMPLE_SLOTS));
            end
            OP_TICK: begin
                case (r_phase)
                    PH_SETTLE: begin
                        n_settle = settle_inc;
                        if (settle_inc >= i_settle_ticks) begin
                            n_idx              = IW'(1);
                            res.move_start     = 1'b1;
                            res.move_count     = 32'(i_segment_pulses);
                            res.move_direction = r_dir;
                            n_phase            = PH_MOVE;
                        end
                    end
                    PH_MOVE: begin
                        if (i_pulses_done) begin
                            res.deviation      = diff;
                            res.deviation_flag = diff_big;
                            n_phase            = PH_SAMPLE;
                        end
                    end
                    PH_SAMPLE: begin
                        we = 1'b1;
                        if (r_idx >= LAST_IDX) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_idx              = IW'(r_idx + 1'b1);
                            res.move_start     = 1'b1;
                            res.move_count     = diff_abs;
                            res.move_direction = r_dir;
                            n_phase            = PH_MOVE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        res.phase         = phase_code(n_phase);
        res.samples_taken = (n_phase == PH_DONE) ? 8'(SAMPLE_SLOTS) : 8'(n_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_idx    <= '0;
            r_settle <= '0;
            r_origin <= '0;
            r_dir    <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_settle <= n_settle;
            r_origin <= n_origin;
            r_dir    <= n_dir;
        end
    end

    assign o_res       = res;
    assign o_mem_we    = i_accept && we;
    assign o_mem_wdata = {i_encoder_position, i_analog_level};
    assign o_mem_re    = i_accept && re;
    assign o_mem_raddr = IW'(i_read_index);

    a_start_settles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_operation == OP_START |=> r_phase == PH_SETTLE && r_idx == '0)
        else $error("start did not enter settling");

    a_stop_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_operation == OP_STOP |=> r_phase == PH_IDLE)
        else $error("stop did not return to idle");

    a_move_enters_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && res.move_start |=> r_phase == PH_MOVE && r_idx != '0)
        else $error("move command without moving phase");

    a_mem_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_we && o_mem_re))
        else $error("sample store written and read by one transaction");

endmodule

### sv/smss_pipe.sv
module smss_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  smss_pkg::t_result          i_res,
    input  logic [smss_pkg::MEM_W-1:0] i_rd_data,
    input  logic                       i_stall,
    output logic                       o_ready,
    output logic                       o_valid,
    output smss_pkg::t_result          o_res,
    output logic [smss_pkg::POS_W-1:0] o_stored_position,
    output logic [smss_pkg::LVL_W-1:0] o_stored_level
);

    import smss_pkg::*;

    logic          r_s1_valid, n_s1_valid;
    t_result       r_s1;
    logic          r_out_valid, n_out_valid;
    t_result       r_out;
    logic [POS_W-1:0] r_out_pos;
    logic [LVL_W-1:0] r_out_lvl;
    logic          s1_adv;

    // stage one waits on the store read register, then moves to the output register
    always_comb begin
        s1_adv      = r_s1_valid && (!r_out_valid || !i_stall);
        o_ready     = !r_s1_valid || s1_adv;
        n_s1_valid  = i_accept || (r_s1_valid && !s1_adv);
        n_out_valid = s1_adv || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_res;
        end
        if (s1_adv) begin
            r_out     <= r_s1;
            r_out_pos <= r_s1.rd_hit ? i_rd_data[MEM_W-1:LVL_W] : '0;
            r_out_lvl <= r_s1.rd_hit ? i_rd_data[LVL_W-1:0] : '0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_res             = r_out;
    assign o_stored_position = r_out_pos;
    assign o_stored_level    = r_out_lvl;

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1))
        else $error("waiting transaction lost in stage one");

    a_no_accept_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> o_ready)
        else $error("transaction taken while stage one blocked");

endmodule

### sv/segmented_move_sample_sequencer.sv
// Scan recorder that sequences moves of a pulse generator to equally spaced
// targets and stores one sample (encoder position, analog level) after each.
// One transaction is taken every clock cycle while the output is not stalled;
// its result leaves through the registered read of the sample store followed
// by the output register, and output stalls back up through those two
// registers only. Each transaction does at most one write or one read of the
// SAMPLE_SLOTS-entry sample store, so no forwarding is needed and no clearing
// pass follows reset; slots not written since reset read back undefined.
module segmented_move_sample_sequencer #(
    parameter int SAMPLE_SLOTS = smss_pkg::SAMPLE_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_operation,
    input  logic                          i_direction,
    input  logic signed [31:0]            i_encoder_position,
    input  logic [9:0]                    i_analog_level,
    input  logic                          i_pulses_done,
    input  logic [6:0]                    i_read_index,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_move_start,
    output logic [31:0]                   o_move_count,
    output logic                          o_move_direction,
    output logic                          o_move_abort,
    output logic signed [31:0]            o_deviation,
    output logic                          o_deviation_flag,
    output logic [2:0]                    o_phase,
    output logic [7:0]                    o_samples_taken,
    output logic signed [31:0]            o_stored_position,
    output logic [9:0]                    o_stored_level,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [smss_pkg::PADDR_W-1:0]  paddr,
    input  logic [smss_pkg::PDATA_W-1:0]  pwdata,
    output logic [smss_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import smss_pkg::*;

    localparam int IW = $clog2(SAMPLE_SLOTS);

    logic [CFG_W-1:0] r_segment;
    logic [CFG_W-1:0] r_settle_ticks;
    logic [CFG_W-1:0] r_rate;

    logic             accept;
    logic             ready;
    t_result          res;
    t_result          out_res;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [MEM_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IW-1:0]    mem_raddr;
    logic [MEM_W-1:0] mem_rdata;
    logic [POS_W-1:0] stored_pos;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment      <= SEGMENT_RST;
            r_settle_ticks <= SETTLE_RST;
            r_rate         <= RATE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SEGMENT: r_segment      <= pwdata[CFG_W-1:0];
                REG_SETTLE:  r_settle_ticks <= pwdata[CFG_W-1:0];
                REG_RATE:    r_rate         <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SEGMENT: prdata = PDATA_W'(r_segment);
            REG_SETTLE:  prdata = PDATA_W'(r_settle_ticks);
            REG_RATE:    prdata = PDATA_W'(r_rate);
            default:     prdata = '0;
        endcase
    end

    assign o_stall = !ready;
    assign accept  = i_valid && ready;

    smss_ctrl #(
        .SAMPLE_SLOTS (SAMPLE_SLOTS),
        .IW           (IW)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_operation        (i_operation),
        .i_direction        (i_direction),
        .i_encoder_position (i_encoder_position),
        .i_analog_level     (i_analog_level),
        .i_pulses_done      (i_pulses_done),
        .i_read_index       (i_read_index),
        .i_segment_pulses   (r_segment),
        .i_settle_ticks     (r_settle_ticks),
        .o_res              (res),
        .o_mem_we           (mem_we),
        .o_mem_waddr        (mem_waddr),
        .o_mem_wdata        (mem_wdata),
        .o_mem_re           (mem_re),
        .o_mem_raddr        (mem_raddr)
    );

    smss_ram #(
        .WIDTH (MEM_W),
        .DEPTH (SAMPLE_SLOTS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    smss_pipe u_pipe (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_res             (res),
        .i_rd_data         (mem_rdata),
        .i_stall           (i_stall),
        .o_ready           (ready),
        .o_valid           (o_valid),
        .o_res             (out_res),
        .o_stored_position (stored_pos),
        .o_stored_level    (o_stored_level)
    );

    assign o_move_start      = out_res.move_start;
    assign o_move_count      = out_res.move_count;
    assign o_move_direction  = out_res.move_direction;
    assign o_move_abort      = out_res.move_abort;
    assign o_deviation       = out_res.deviation;
    assign o_deviation_flag  = out_res.deviation_flag;
    assign o_phase           = out_res.phase;
    assign o_samples_taken   = out_res.samples_taken;
    assign o_stored_position = stored_pos;

endmodule

### sim/segmented_move_sample_sequencer_tb.sv
`timescale 1ns / 100ps

module segmented_move_sample_sequencer_tb;
    import smss_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int SLOTS = SAMPLE_SLOTS_DEF;

    typedef struct packed {
        logic [1:0]  op;
        logic        dir;
        logic [31:0] enc;
        logic [9:0]  lvl;
        logic        done;
        logic [6:0]  ridx;
    } t_scan_item;

    typedef struct packed {
        logic        move_start;
        logic [31:0] move_count;
        logic        move_direction;
        logic        move_abort;
        logic [31:0] deviation;
        logic        deviation_flag;
        logic [2:0]  phase;
        logic [7:0]  samples_taken;
        logic [31:0] stored_position;
        logic [9:0]  stored_level;
    } t_scan_result;

    class scan_checker;
        logic [15:0]  seg_pulses;
        logic [15:0]  settle_ticks;
        logic [15:0]  pulse_rate;
        logic [2:0]   phase;
        int unsigned  idx;
        logic [15:0]  settle_cnt;
        logic [31:0]  origin;
        logic         rec_dir;
        logic [31:0]  pos_mem [SLOTS];
        logic [9:0]   lvl_mem [SLOTS];
        bit           written [SLOTS];
        t_scan_result due_results [$];
        int           errors;

        function new();
            seg_pulses = SEGMENT_RST;
            settle_ticks = SETTLE_RST;
            pulse_rate = RATE_RST;
            phase = PHASE_IDLE;
            idx = 0;
            settle_cnt = '0;
            origin = '0;
            rec_dir = 1'b0;
            errors = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_reg(logic [1:0] r, logic [15:0] v);
            case (r)
                REG_SEGMENT: seg_pulses = v;
                REG_SETTLE:  settle_ticks = v;
                REG_RATE:    pulse_rate = v;
                default:     ;
            endcase
        endfunction

        function logic [31:0] target(int unsigned k);
            logic [31:0] span;
            span = 32'(seg_pulses) * 32'(k);
            return rec_dir ? origin - span : origin + span;
        endfunction

        function void note_item(t_scan_item it);
            t_scan_result r;
            logic [31:0]  d;
            r = '0;
            case (it.op)
                OP_START: begin
                    idx = 0;
                    origin = it.enc;
                    pos_mem[0] = it.enc;
                    lvl_mem[0] = it.lvl;
                    written[0] = 1'b1;
                    rec_dir = it.dir;
                    settle_cnt = '0;
                    phase = PHASE_SETTLE;
                end
                OP_STOP: begin
                    r.move_abort = 1'b1;
                    phase = PHASE_IDLE;
                end
                OP_READ: begin
                    if (int'(it.ridx) < SLOTS) begin
                        r.stored_position = pos_mem[it.ridx];
                        r.stored_level = lvl_mem[it.ridx];
                    end
                end
                default: begin
                    case (phase)
                        PHASE_SETTLE: begin
                            if (settle_cnt != 16'hFFFF) settle_cnt++;
                            if (settle_cnt >= settle_ticks) begin
                                idx = 1;
                                r.move_start = 1'b1;
                                r.move_count = 32'(seg_pulses);
                                r.move_direction = rec_dir;
                                phase = PHASE_MOVE;
                            end
                        end
                        PHASE_MOVE: begin
                            if (it.done) begin
                                d = target(idx) - it.enc;
                                r.deviation = d;
                                r.deviation_flag = !(d == 32'd0 || d == 32'd1
                                                     || d == 32'hFFFF_FFFF);
                                phase = PHASE_SAMPLE;
                            end
                        end
                        PHASE_SAMPLE: begin
                            if (idx < SLOTS) begin
                                pos_mem[idx] = it.enc;
                                lvl_mem[idx] = it.lvl;
                                written[idx] = 1'b1;
                            end
                            if (idx >= SLOTS - 1) begin
                                phase = PHASE_DONE;
                            end else begin
                                idx++;
                                d = target(idx) - it.enc;
                                r.move_count = d[31] ? 32'd0 - d : d;
                                r.move_start = 1'b1;
                                r.move_direction = rec_dir;
                                phase = PHASE_MOVE;
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
            r.phase = phase;
            r.samples_taken = (phase == PHASE_DONE) ? 8'(SLOTS) : 8'(idx);
            due_results.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_scan_result got);
            t_scan_result want;
            if (due_results.size() == 0) begin
                $display("%0t: result with no transaction pending", $time);
                errors++;
                return;
            end
            want = due_results.pop_front();
            cmp("move_start", 32'(want.move_start), 32'(got.move_start));
            cmp("move_count", want.move_count, got.move_count);
            cmp("move_direction", 32'(want.move_direction), 32'(got.move_direction));
            cmp("move_abort", 32'(want.move_abort), 32'(got.move_abort));
            cmp("deviation", want.deviation, got.deviation);
            cmp("deviation_flag", 32'(want.deviation_flag), 32'(got.deviation_flag));
            cmp("phase", 32'(want.phase), 32'(got.phase));
            cmp("samples_taken", 32'(want.samples_taken), 32'(got.samples_taken));
            cmp("stored_position", want.stored_position, got.stored_position);
            cmp("stored_level", 32'(want.stored_level), 32'(got.stored_level));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_operation;
    logic                 i_direction;
    logic signed [31:0]   i_encoder_position;
    logic [9:0]           i_analog_level;
    logic                 i_pulses_done;
    logic [6:0]           i_read_index;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_move_start;
    logic [31:0]          o_move_count;
    logic                 o_move_direction;
    logic                 o_move_abort;
    logic signed [31:0]   o_deviation;
    logic                 o_deviation_flag;
    logic [2:0]           o_phase;
    logic [7:0]           o_samples_taken;
    logic signed [31:0]   o_stored_position;
    logic [9:0]           o_stored_level;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    scan_checker  sb;
    t_scan_result seen;
    bit           src_quiet;
    bit           hold_req;

    segmented_move_sample_sequencer i_dut (.*);

    initial i_clk = 1'b0;
    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    initial begin
        #(HALF_PERIOD * 2 * 400000);
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen.move_start = o_move_start;
            seen.move_count = o_move_count;
            seen.move_direction = o_move_direction;
            seen.move_abort = o_move_abort;
            seen.deviation = o_deviation;
            seen.deviation_flag = o_deviation_flag;
            seen.phase = o_phase;
            seen.samples_taken = o_samples_taken;
            seen.stored_position = o_stored_position;
            seen.stored_level = o_stored_level;
            sb.check_result(seen);
        end
    end

    // receiver stalls, with a long hold-off on request
    initial begin
        int stall_left;
        int cyc;
        int r;
        bit quiet;
        i_stall = 1'b0;
        stall_left = 0;
        cyc = 0;
        quiet = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 60;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                r = $urandom_range(0, 99);
                if (!quiet && r < 20) stall_left = $urandom_range(1, 3);
                else if (!quiet && r < 22) stall_left = $urandom_range(8, 30);
            end
        end
    end

    function automatic t_scan_item mk(logic [1:0] op, logic dir, logic [31:0] enc,
                                      logic [9:0] lvl, logic done, logic [6:0] ridx);
        t_scan_item it;
        it.op = op;
        it.dir = dir;
        it.enc = enc;
        it.lvl = lvl;
        it.done = done;
        it.ridx = ridx;
        return it;
    endfunction

    function automatic logic [31:0] jitter();
        case ($urandom_range(0, 9))
            7, 8:    return 32'($urandom_range(0, 2000)) - 32'd1000;
            9:       return $urandom;
            default: return 32'($urandom_range(0, 6)) - 32'd3;
        endcase
    endfunction

    function automatic t_scan_item random_item(int noise);
        t_scan_item it;
        int r;
        it = mk(OP_TICK, 1'($urandom_range(0, 1)), $urandom, 10'($urandom_range(0, 1023)),
                1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
        r = $urandom_range(0, 99);
        if (r < noise) begin
            case ($urandom_range(0, 2))
                0:       it.op = OP_STOP;
                1:       it.op = OP_START;
                default: it.op = OP_READ;
            endcase
        end else if (r < noise + 8) begin
            it.op = OP_READ;
        end else begin
            case (sb.phase)
                PHASE_SETTLE: it.op = OP_TICK;
                PHASE_MOVE: begin
                    it.done = ($urandom_range(0, 3) != 0);
                    if (it.done) it.enc = sb.target(sb.idx) + jitter();
                end
                PHASE_SAMPLE: it.enc = sb.target(sb.idx + 1) + jitter();
                default: begin
                    if ($urandom_range(0, 2) == 0) it.op = OP_START;
                    else if ($urandom_range(0, 1) == 0) it.op = OP_READ;
                end
            endcase
        end
        // only slots written since reset may be read back
        if (it.op == OP_READ) begin
            if (!sb.written[0]) it.op = OP_TICK;
            else while (!sb.written[it.ridx]) it.ridx = 7'($urandom_range(0, 127));
        end
        return it;
    endfunction

    task automatic drive(input t_scan_item it);
        int gap;
        int r;
        i_valid <= 1'b1;
        i_operation <= it.op;
        i_direction <= it.dir;
        i_encoder_position <= it.enc;
        i_analog_level <= it.lvl;
        i_pulses_done <= it.done;
        i_read_index <= it.ridx;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(it);
        r = $urandom_range(0, 99);
        if (src_quiet || r < 60) gap = 0;
        else if (r < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] r, input logic [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(r, v);
    endtask

    task automatic wait_drained();
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int seg;
        int settle;
        int rate;
        int noise;
        int count;
        sb = new();
        src_quiet = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_TICK;
        i_direction = 1'b0;
        i_encoder_position = '0;
        i_analog_level = '0;
        i_pulses_done = 1'b0;
        i_read_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(REG_SEGMENT, 16'd1);
        write_reg(REG_SETTLE, 16'd0);
        write_reg(REG_RATE, 16'd1);

        // deviation edges around zero and the full-magnitude move count
        drive(mk(OP_START, 1'b0, 32'h7FFF_FFFF, 10'd1023, 1'b0, 7'd127));
        drive(mk(OP_TICK, 1'b1, 32'h1234_5678, 10'd5, 1'b0, 7'd127));
        drive(mk(OP_TICK, 1'b0, 32'hFFFF_FFFF, 10'd6, 1'b0, 7'd0));
        drive(mk(OP_TICK, 1'b0, 32'h8000_0000, 10'd7, 1'b1, 7'd0));
        drive(mk(OP_TICK, 1'b1, 32'h0000_0001, 10'd0, 1'b1, 7'd64));
        drive(mk(OP_TICK, 1'b0, 32'h8000_0000, 10'd9, 1'b1, 7'd1));
        drive(mk(OP_TICK, 1'b0, 32'h8000_0002, 10'd512, 1'b0, 7'd2));
        drive(mk(OP_TICK, 1'b0, 32'h8000_0003, 10'd11, 1'b1, 7'd3));
        drive(mk(OP_TICK, 1'b1, 32'h8000_0003, 10'd12, 1'b0, 7'd4));
        drive(mk(OP_TICK, 1'b0, 32'h8000_0001, 10'd13, 1'b1, 7'd5));
        drive(mk(OP_TICK, 1'b0, 32'h0000_0000, 10'd1023, 1'b1, 7'd6));
        drive(mk(OP_TICK, 1'b0, 32'h8000_0006, 10'd15, 1'b1, 7'd7));
        drive(mk(OP_READ, 1'b0, 32'h0, 10'd0, 1'b0, 7'd0));
        drive(mk(OP_READ, 1'b1, 32'hFFFF_FFFF, 10'd1023, 1'b1, 7'd1));
        drive(mk(OP_READ, 1'b0, 32'h0, 10'd0, 1'b0, 7'd4));
        // restart in the middle of a scan, backward across the wrap
        drive(mk(OP_START, 1'b1, 32'h8000_0000, 10'd0, 1'b1, 7'd0));
        drive(mk(OP_TICK, 1'b0, 32'h0, 10'd1, 1'b1, 7'd0));
        drive(mk(OP_TICK, 1'b0, 32'h7FFF_FFFF, 10'd2, 1'b1, 7'd0));
        drive(mk(OP_STOP, 1'b1, 32'h5555_AAAA, 10'd3, 1'b1, 7'd127));
        drive(mk(OP_TICK, 1'b0, 32'hAAAA_5555, 10'd4, 1'b1, 7'd0));
        drive(mk(OP_READ, 1'b0, 32'h0, 10'd0, 1'b0, 7'd0));
        drive(mk(OP_STOP, 1'b0, 32'h0, 10'd0, 1'b0, 7'd0));
        i_valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    seg = 65535; settle = 0; rate = 65535; noise = 0; count = 450;
                end
                1: begin
                    seg = 1; settle = 65535; rate = 1; noise = 10; count = 100;
                end
                default: begin
                    seg = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 20)
                                                      : $urandom_range(1, 65535);
                    settle = $urandom_range(0, 3);
                    rate = $urandom_range(1, 65535);
                    noise = 4;
                    count = 175;
                end
            endcase
            write_reg(REG_SEGMENT, 16'(seg));
            write_reg(REG_SETTLE, 16'(settle));
            write_reg(REG_RATE, 16'(rate));
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < count; n++) begin
                if (n % 40 == 0) src_quiet = (ph == 2 && n == 0) || ($urandom_range(0, 2) == 0);
                drive(random_item(noise));
            end
            i_valid <= 1'b0;
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
